>>> rtl/core/murmur2a_hash32_macros.svh
// ----------------------------------------------------------------------------
// murmur2a_hash32_macros: assertion macros
// Assertion macros shared by the checker of the 32-bit MurmurHash2A block.
// ----------------------------------------------------------------------------
`ifndef MURMUR2A_HASH32_MACROS_SVH
`define MURMUR2A_HASH32_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define MM2A_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("MurmurHash2A checker: same-cycle property failed");

// Next-cycle implication, inactive while reset is asserted.
`define MM2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("MurmurHash2A checker: next-cycle property failed");

// Same-cycle implication that is checked during reset as well.
`define MM2A_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("MurmurHash2A checker: reset property failed");

`endif

>>> rtl/core/mm2a_pkg.sv
// ----------------------------------------------------------------------------
// mm2a_pkg: shared types and constants
// Hash constants, queue entry layout and sequencer codes of the MurmurHash2A
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package mm2a_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;
    localparam logic [2:0]  FULL_BYTES  = 3'd4;

    // One classified message word as it waits in the queue.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;   // already clamped to four
        logic        first;    // opens a message: hash starts from the seed
        logic        last;     // closes a message
        logic [31:0] total;    // byte count of the message up to this word
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry ent;
    } t_push;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KMUL1,
        ST_KMUL2,
        ST_HMIX,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_BLOCK,
        PH_TAIL,
        PH_LEN
    } t_phase;

    function automatic logic [31:0] tail_mask(input logic [2:0] nbytes);
        logic [31:0] m;
        case (nbytes)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mm2a_front.sv
// ----------------------------------------------------------------------------
// mm2a_front: input classification
// Accepts message words, clamps the byte count, tracks message boundaries and
// the running byte total, and pushes one entry per word into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2a_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [31:0]     i_data_word,
    input  wire logic [2:0]      i_valid_bytes,
    input  wire logic            i_last,
    input  wire logic            i_q_full,
    output mm2a_pkg::t_push      o_push
);

    logic        r_in_msg;
    logic        n_in_msg;
    logic [31:0] r_total;
    logic [31:0] n_total;
    logic [2:0]  nb_sat;
    logic        accept;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    always_comb begin
        // Only the last word may be short; counts above four clamp to four.
        if (!i_last) begin
            nb_sat = mm2a_pkg::FULL_BYTES;
        end else if (i_valid_bytes > mm2a_pkg::FULL_BYTES) begin
            nb_sat = mm2a_pkg::FULL_BYTES;
        end else begin
            nb_sat = i_valid_bytes;
        end
        n_total  = (r_in_msg ? r_total : 32'd0) + {29'd0, nb_sat};
        n_in_msg = !i_last;

        o_push.push       = accept;
        o_push.ent.word   = i_data_word;
        o_push.ent.nbytes = nb_sat;
        o_push.ent.first  = !r_in_msg;
        o_push.ent.last   = i_last;
        o_push.ent.total  = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
        end else if (accept) begin
            r_in_msg <= n_in_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_total <= n_total;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mm2a_queue.sv
// ----------------------------------------------------------------------------
// mm2a_queue: entry queue
// Small first-in first-out buffer that decouples classification from the
// mixing sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2a_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mm2a_pkg::t_push  i_push,
    output logic                  o_full,
    output logic                  o_valid,
    output mm2a_pkg::t_entry      o_ent,
    input  wire logic             i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mm2a_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rd];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.ent;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mm2a_back.sv
// ----------------------------------------------------------------------------
// mm2a_back: mixing sequencer
// Carries out the block, tail and length mixes and the final avalanche on one
// shared constant multiplier, and holds the seed and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2a_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [31:0]       i_cfg_data,
    input  wire logic              i_q_valid,
    input  wire mm2a_pkg::t_entry  i_q_ent,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [31:0]            o_hash
);

    mm2a_pkg::t_state r_state;
    mm2a_pkg::t_state n_state;
    mm2a_pkg::t_phase r_phase;
    mm2a_pkg::t_phase n_phase;
    mm2a_pkg::t_entry r_ent;
    mm2a_pkg::t_entry n_ent;
    logic [31:0]      r_h;
    logic [31:0]      n_h;
    logic [31:0]      r_k;
    logic [31:0]      n_k;
    logic [31:0]      r_seed;
    logic [31:0]      r_hash;
    logic [31:0]      n_hash;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [31:0]      operand;
    logic [31:0]      mul_a;
    logic [31:0]      prod;
    logic             out_free;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_hash      = r_hash;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign prod        = mul_a * mm2a_pkg::MIX_MUL;

    always_comb begin
        case (r_phase)
            mm2a_pkg::PH_BLOCK: operand = r_ent.word;
            mm2a_pkg::PH_TAIL: begin
                // A full last word was already mixed as a block: empty tail.
                if (r_ent.nbytes == mm2a_pkg::FULL_BYTES) begin
                    operand = 32'd0;
                end else begin
                    operand = r_ent.word & mm2a_pkg::tail_mask(r_ent.nbytes);
                end
            end
            mm2a_pkg::PH_LEN:  operand = r_ent.total;
            default:           operand = r_ent.word;
        endcase

        case (r_state)
            mm2a_pkg::ST_KMUL1: mul_a = operand;
            mm2a_pkg::ST_KMUL2: mul_a = r_k ^ (r_k >> mm2a_pkg::MIX_SHIFT);
            mm2a_pkg::ST_HMIX:  mul_a = r_h;
            mm2a_pkg::ST_FIN:   mul_a = r_h ^ (r_h >> mm2a_pkg::FIN_SHIFT_A);
            default:            mul_a = r_h;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_ent       = r_ent;
        n_h         = r_h;
        n_k         = r_k;
        n_hash      = r_hash;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        case (r_state)
            mm2a_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_ent = i_q_ent;
                    if (i_q_ent.first) begin
                        n_h = r_seed;
                    end
                    if (!i_q_ent.last || i_q_ent.nbytes == mm2a_pkg::FULL_BYTES) begin
                        n_phase = mm2a_pkg::PH_BLOCK;
                    end else begin
                        n_phase = mm2a_pkg::PH_TAIL;
                    end
                    n_state = mm2a_pkg::ST_KMUL1;
                end
            end
            mm2a_pkg::ST_KMUL1: begin
                n_k     = prod;
                n_state = mm2a_pkg::ST_KMUL2;
            end
            mm2a_pkg::ST_KMUL2: begin
                n_k     = prod;
                n_state = mm2a_pkg::ST_HMIX;
            end
            mm2a_pkg::ST_HMIX: begin
                n_h = prod ^ r_k;
                case (r_phase)
                    mm2a_pkg::PH_BLOCK: begin
                        if (r_ent.last) begin
                            n_phase = mm2a_pkg::PH_TAIL;
                            n_state = mm2a_pkg::ST_KMUL1;
                        end else begin
                            n_state = mm2a_pkg::ST_IDLE;
                        end
                    end
                    mm2a_pkg::PH_TAIL: begin
                        n_phase = mm2a_pkg::PH_LEN;
                        n_state = mm2a_pkg::ST_KMUL1;
                    end
                    default: begin
                        n_state = mm2a_pkg::ST_FIN;
                    end
                endcase
            end
            mm2a_pkg::ST_FIN: begin
                n_h     = prod;
                n_state = mm2a_pkg::ST_OUT;
            end
            mm2a_pkg::ST_OUT: begin
                if (out_free) begin
                    n_hash      = r_h ^ (r_h >> mm2a_pkg::FIN_SHIFT_B);
                    n_out_valid = 1'b1;
                    n_state     = mm2a_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mm2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mm2a_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_seed      <= 32'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_ent   <= n_ent;
        r_h     <= n_h;
        r_k     <= n_k;
        r_hash  <= n_hash;
    end

endmodule

`default_nettype wire

>>> rtl/core/murmur2a_hash32.sv
// Sequencing: the sequencer takes one word from the queue at a time and finishes it first;
// an inner word needs the three products of its mix on the single constant multiplier,
// a last word is mixed as a block when full and then adds the tail mix, the length mix
// and the avalanche, and a result stall holds the sequencer until its hash is placed.
// Reset: synchronous, active low; empties the queue, idles the sequencer, drops the result
// and loads a zero seed. No clearing pass is needed, so words are taken right after reset.
// ----------------------------------------------------------------------------
// murmur2a_hash32: streaming 32-bit MurmurHash2A
// Words enter a classifying front end, wait in a short queue and are mixed
// by a multi-cycle sequencer that emits one hash per message.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur2a_hash32 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Seed register write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    // Message word channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_last,
    // Hash result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_hash
);

    // The front end takes a word whenever the queue has room. It clamps the
    // byte count (only a last word may be short), marks the first word of
    // each message and keeps the running byte total, which wraps at 2^32.
    mm2a_pkg::t_push  push;
    mm2a_pkg::t_entry q_ent;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;

    mm2a_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last        (i_last),
        .i_q_full      (q_full),
        .o_push        (push)
    );

    // The queue lets the producer keep streaming while the sequencer works
    // through the extra tail, length and avalanche steps of a last word.
    mm2a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_ent),
        .i_pop   (q_pop)
    );

    // The sequencer pops one entry at a time. Each mix forms three products in turn:
    // k times the constant, the xor-shifted k times the constant again, and
    // the hash times the constant folded with k. A last word adds the tail
    // and length mixes, then the avalanche, and the hash is placed in an
    // output register that can be refilled in the cycle it is taken.
    mm2a_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_ent     (q_ent),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hash      (o_hash)
    );

endmodule

`default_nettype wire

>>> rtl/core/murmur2a_hash32_checker.sv
// ----------------------------------------------------------------------------
// murmur2a_hash32_checker: port-level assertions
// Watches the ports of the hash block for reset, flow control and result
// holding behavior.
// ----------------------------------------------------------------------------
`default_nettype none
`include "murmur2a_hash32_macros.svh"

module murmur2a_hash32_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_hash
);

    // A cycle of reset leaves no result pending and the queue not full (no input stall).
    `MM2A_ASSERT_ALWAYS(a_reset_clean, i_clk, !$past(i_rst_n), !o_out_valid && !o_in_stall)

    // The queue can only fill up right after a word was taken.
    `MM2A_ASSERT_NOW(a_stall_after_push, i_clk, i_rst_n, $rose(o_in_stall), $past(i_in_valid && !o_in_stall))

    // A stalled result stays offered with the same hash.
    `MM2A_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_hash))

endmodule

bind murmur2a_hash32 murmur2a_hash32_checker u_checker (.*);

`default_nettype wire
